// File: hdl/fcmb_pkg.sv
`default_nettype none

package fcmb_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned ItemBitsDefault = 32;

  // Widths of the fixed result fields
  localparam int unsigned OutCntBits = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef struct packed {
    logic                  accepted;
    logic [OutCntBits-1:0] match_count;
    logic [OutCntBits-1:0] entry_count;
    logic                  is_empty;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/fcmb_out_reg.sv
`default_nettype none

module fcmb_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_valid_i,
  output logic                  load_ready_o,
  input  wire fcmb_pkg::result_t load_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fcmb_pkg::result_t     out_o
);

  logic              valid_q;
  logic              valid_d;
  fcmb_pkg::result_t data_q;

  // Take a new result when empty or when the held one leaves this cycle
  assign load_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_valid_i && load_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      data_q <= load_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

`default_nettype wire

// File: hdl/fixed_capacity_multiset_bag.sv
// Fixed-capacity multiset (array bag).
//
// Input channel: in_valid_i / in_ready_o carry one command transaction with
// operation_i (add, remove first match, clear, query) and item_value_i.
// Output channel: out_valid_o / out_ready_i carry one result transaction per
// command: accepted_o, match_count_o, entry_count_o and is_empty_o.
//
// Entries live in a memory of CAPACITY words with a registered read; one
// command is worked on at a time. Add and clear go straight to the response
// state. Query scans all N stored entries, as the read port visits one entry
// per cycle. Remove scans up to the first match, then reads the last entry
// and writes it into the freed slot; with no match it scans all N entries.
// Every result passes through the response state and the output register,
// and the block returns to idle before the next command is taken.
//
// Reset clears the entry count and the control state; memory contents are
// not cleared and are never read before being written.
// The result sits in an output register: a stalled receiver does not block
// the next command, which is taken and worked on until its own result is
// ready and the output register is still full.
`default_nettype none

module fixed_capacity_multiset_bag #(
  parameter int unsigned CAPACITY  = fcmb_pkg::CapacityDefault,
  parameter int unsigned ITEM_BITS = fcmb_pkg::ItemBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic signed [31:0] item_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic [4:0]       match_count_o,
  output logic [4:0]       entry_count_o,
  output logic             is_empty_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OutW  = fcmb_pkg::OutCntBits;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_MOVE  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Command being worked on
  fcmb_pkg::op_e        op_q, op_d;
  logic [ITEM_BITS-1:0] val_q, val_d;

  // Stored entry count
  logic [CntW-1:0] total_q, total_d;

  // Scan control: issue index, compare stage, first-match slot
  logic [CntW-1:0]  idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  logic [AddrW-1:0] where_q, where_d;

  // Result under construction
  logic            acc_q, acc_d;
  logic [CntW-1:0] match_q, match_d;

  // Entry memory
  logic [ITEM_BITS-1:0] mem_q [CAPACITY];
  logic [ITEM_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  logic [ITEM_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AddrW-1:0]     mem_raddr;

  logic                 in_fire;
  logic                 hit;
  logic                 scan_done;
  logic [CntW-1:0]      total_m1;
  logic [ITEM_BITS-1:0] in_val;

  // Result hand-off to the output register
  logic              res_valid;
  logic              res_ready;
  fcmb_pkg::result_t res;
  fcmb_pkg::result_t out_res;
  logic [CntW+OutW-1:0] match_wide;
  logic [CntW+OutW-1:0] total_wide;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Keep the low ITEM_BITS of the 32-bit pattern, zero above it
  assign in_val   = ITEM_BITS'($unsigned(item_value_i));
  assign total_m1 = total_q - 1'b1;

  // Compare stage sees the registered read data of the previous cycle
  assign hit       = cmp_vld_q && (rdata_q == val_q);
  assign scan_done = !cmp_vld_q && (idx_q == total_q);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    total_d   = total_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    where_d   = where_q;
    acc_d     = acc_q;
    match_d   = match_q;
    mem_we    = 1'b0;
    mem_waddr = total_q[AddrW-1:0];
    mem_wdata = in_val;
    mem_re    = 1'b0;
    mem_raddr = idx_q[AddrW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d    = fcmb_pkg::op_e'(operation_i);
          val_d   = in_val;
          idx_d   = '0;
          match_d = '0;
          acc_d   = 1'b0;
          state_d = ST_RESP;
          unique case (fcmb_pkg::op_e'(operation_i))
            fcmb_pkg::OP_ADD: begin
              // Append at the end of the occupied part when there is room
              if (total_q < CntW'(CAPACITY)) begin
                mem_we  = 1'b1;
                total_d = total_q + 1'b1;
                acc_d   = 1'b1;
              end
            end
            fcmb_pkg::OP_CLEAR: begin
              total_d = '0;
              acc_d   = 1'b1;
            end
            fcmb_pkg::OP_REMOVE, fcmb_pkg::OP_QUERY: begin
              if (total_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle while entries remain
        if (idx_q < total_q) begin
          mem_re    = 1'b1;
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[AddrW-1:0];
        end
        if (op_q == fcmb_pkg::OP_REMOVE) begin
          if (hit) begin
            where_d   = cmp_idx_q;
            cmp_vld_d = 1'b0;
            state_d   = ST_MOVE;
          end else if (scan_done) begin
            acc_d   = 1'b0;
            state_d = ST_RESP;
          end
        end else begin
          if (hit) begin
            match_d = match_q + 1'b1;
          end
          if (scan_done) begin
            acc_d   = (match_q != '0);
            state_d = ST_RESP;
          end
        end
      end

      ST_MOVE: begin
        // Fetch the last entry to fill the freed slot
        mem_re    = 1'b1;
        mem_raddr = total_m1[AddrW-1:0];
        state_d   = ST_WRITE;
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = where_q;
        mem_wdata = rdata_q;
        total_d   = total_m1;
        acc_d     = 1'b1;
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        // Hold until the output register has room
        if (res_ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    where_q   <= where_d;
    acc_q     <= acc_d;
    match_q   <= match_d;
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Report the low bits of the counts
  assign match_wide = (CntW + OutW)'(match_q);
  assign total_wide = (CntW + OutW)'(total_q);

  assign res_valid       = (state_q == ST_RESP);
  assign res.accepted    = acc_q;
  assign res.match_count = match_wide[OutW-1:0];
  assign res.entry_count = total_wide[OutW-1:0];
  assign res.is_empty    = (total_q == '0);

  fcmb_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .load_ready_o (res_ready),
    .load_i       (res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_res)
  );

  assign accepted_o    = out_res.accepted;
  assign match_count_o = out_res.match_count;
  assign entry_count_o = out_res.entry_count;
  assign is_empty_o    = out_res.is_empty;

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= total_q)
    else $error("scan index past entry count");

  a_write_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |=> total_q == $past(total_q) - 1'b1)
    else $error("remove did not shrink the count by one");

  a_add_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && state_q == ST_IDLE |-> total_q < CntW'(CAPACITY))
    else $error("append into a full store");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fcmb_pkg::*;

  localparam int unsigned BagCapacity    = fcmb_pkg::CapacityDefault;
  localparam time         ClkPeriod      = 8ns;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned ItemsPerPhase  = 617;   // three phases, 1851 random commands
  localparam int unsigned DrainCycles    = 40;    // longer than a full scan plus write-back
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned DirectedRows   = 23;

  // Directed rows either carry an expectation typed by hand or take it from
  // the bag predictor below.
  localparam bit      Typed         = 1'b1;
  localparam bit      Predicted     = 1'b0;
  localparam result_t FromPredictor = '0;

  typedef struct {
    op_e         op;
    logic [31:0] value;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } stim_row_t;

  // DUT connections
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] item_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        accepted_o;
  logic [4:0]  match_count_o;
  logic [4:0]  entry_count_o;
  logic        is_empty_o;

  // Bag predictor state: its own copy of the stored entries and the count.
  logic [31:0] bag_entries [BagCapacity];
  int unsigned bag_total;

  // Results owed by the block, oldest first.
  result_t     pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned quiet_cycles;

  fixed_capacity_multiset_bag dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .match_count_o(match_count_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Print one line per mismatch and count it.
  task automatic report_failure(string msg);
    mismatch_count++;
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
  endtask

  // Apply one command to the bag predictor and return the result it owes.
  function automatic result_t apply_bag_command(op_e op, logic [31:0] value);
    result_t     r;
    int unsigned hits;
    int unsigned slot;
    int unsigned i;
    bit          found;
    r     = '0;
    hits  = 0;
    slot  = 0;
    found = 1'b0;
    case (op)
      OP_ADD: begin
        if (bag_total < BagCapacity) begin
          bag_entries[bag_total] = value;
          bag_total++;
          r.accepted = 1'b1;
        end
      end
      OP_REMOVE: begin
        // Take the first match, then fill its slot from the last entry.
        for (i = 0; i < bag_total; i++) begin
          if (!found && bag_entries[i] == value) begin
            found = 1'b1;
            slot  = i;
          end
        end
        if (found) begin
          bag_total--;
          bag_entries[slot] = bag_entries[bag_total];
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        // Old contents stay behind but fall outside the occupied part.
        bag_total  = 0;
        r.accepted = 1'b1;
      end
      default: begin
        for (i = 0; i < bag_total; i++) begin
          if (bag_entries[i] == value) hits++;
        end
        r.accepted    = (hits != 0);
        r.match_count = hits[4:0];
      end
    endcase
    r.entry_count = bag_total[4:0];
    r.is_empty    = (bag_total == 0);
    return r;
  endfunction

  // Offer one command transaction, hold it until accepted, then record what
  // the block owes for it. Entered and left just after a rising edge.
  task automatic send_command(op_e op, logic [31:0] value, bit typed, result_t want);
    result_t predicted;
    bit      taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    item_value_i <= value;
    // Sample the handshake mid-cycle, where nothing is moving.
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    predicted = apply_bag_command(op, value);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker and watchdog. Both look at the channels mid-cycle: a
  // transaction seen here completes at the next rising edge.
  always @(negedge clk_i) begin : check_results
    result_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("FAIL fixed_capacity_multiset_bag");
        $finish;
      end else if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_failure("result with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          if (accepted_o !== want.accepted)
            report_failure($sformatf("accepted got %b want %b", accepted_o, want.accepted));
          if (match_count_o !== want.match_count)
            report_failure($sformatf("match_count got %0d want %0d",
                                     match_count_o, want.match_count));
          if (entry_count_o !== want.entry_count)
            report_failure($sformatf("entry_count got %0d want %0d",
                                     entry_count_o, want.entry_count));
          if (is_empty_o !== want.is_empty)
            report_failure($sformatf("is_empty got %b want %b", is_empty_o, want.is_empty));
        end
        results_seen++;
      end
    end
  end

  initial begin : stimulus
    stim_row_t   directed_rows [DirectedRows];
    logic [31:0] value_pool [6];
    logic [31:0] value;
    op_e         op;
    int unsigned phase;
    int unsigned row;
    int unsigned n;
    int unsigned roll;
    int unsigned add_bias;

    // Hold every input at a known value from time zero.
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_ADD;
    item_value_i   = '0;
    out_ready_i    = 1'b0;
    bag_total      = 0;
    mismatch_count = 0;
    results_seen   = 0;
    quiet_cycles   = 0;
    add_bias       = 50;
    send_idle_pct  = 9;
    recv_idle_pct  = 53;

    // Hand-typed rows: empty store, extremes, add when full, clear. The rest
    // (matches, moves of the last entry) come from the predictor.
    directed_rows = '{
      '{OP_QUERY,  32'h0000_0000,  1, Typed,     {1'b0, 5'd0, 5'd0,  1'b1}},
      '{OP_REMOVE, 32'h0000_0005,  1, Typed,     {1'b0, 5'd0, 5'd0,  1'b1}},
      '{OP_CLEAR,  32'hFFFF_FFFF,  1, Typed,     {1'b1, 5'd0, 5'd0,  1'b1}},
      '{OP_ADD,    32'h8000_0000,  1, Typed,     {1'b1, 5'd0, 5'd1,  1'b0}},
      '{OP_ADD,    32'h7FFF_FFFF,  1, Typed,     {1'b1, 5'd0, 5'd2,  1'b0}},
      '{OP_ADD,    32'hFFFF_FFFF,  1, Predicted, FromPredictor},
      '{OP_ADD,    32'h0000_0000,  1, Predicted, FromPredictor},
      '{OP_ADD,    32'h8000_0000,  1, Predicted, FromPredictor},
      '{OP_QUERY,  32'h8000_0000,  1, Predicted, FromPredictor},
      '{OP_REMOVE, 32'h8000_0000,  1, Predicted, FromPredictor},
      '{OP_QUERY,  32'h8000_0000,  1, Predicted, FromPredictor},
      '{OP_REMOVE, 32'h1234_5678,  1, Predicted, FromPredictor},
      '{OP_QUERY,  32'hFFFF_FFFF,  1, Predicted, FromPredictor},
      '{OP_REMOVE, 32'h7FFF_FFFF,  1, Predicted, FromPredictor},
      '{OP_ADD,    32'hA5A5_5A5A, 13, Predicted, FromPredictor},
      '{OP_ADD,    32'h0000_0001,  1, Typed,     {1'b0, 5'd0, 5'd16, 1'b0}},
      '{OP_QUERY,  32'hA5A5_5A5A,  1, Predicted, FromPredictor},
      '{OP_REMOVE, 32'hA5A5_5A5A,  1, Predicted, FromPredictor},
      '{OP_ADD,    32'h5A5A_A5A5,  1, Predicted, FromPredictor},
      '{OP_REMOVE, 32'h5A5A_A5A5,  1, Predicted, FromPredictor},
      '{OP_CLEAR,  32'h0000_0000,  1, Typed,     {1'b1, 5'd0, 5'd0,  1'b1}},
      '{OP_QUERY,  32'hA5A5_5A5A,  1, Typed,     {1'b0, 5'd0, 5'd0,  1'b1}},
      '{OP_ADD,    32'h0000_0000,  1, Typed,     {1'b1, 5'd0, 5'd1,  1'b0}}
    };

    // A small pool of values keeps removes and queries hitting stored entries.
    value_pool = '{$urandom(), $urandom(), 32'h0000_0001, 32'hFFFF_FFFE,
                   $urandom(), 32'h0000_0000};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // Walk the directed table.
        for (row = 0; row < DirectedRows; row++) begin
          for (n = 0; n < directed_rows[row].reps; n++) begin
            send_command(directed_rows[row].op, directed_rows[row].value,
                         directed_rows[row].typed, directed_rows[row].want);
          end
        end
      end else begin
        // Drop valid and hold off until the block has returned everything.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end

      for (n = 0; n < ItemsPerPhase; n++) begin
        // Drift the fill level between near-empty and full.
        if (n % 50 == 0) begin
          case ($urandom_range(3))
            0:       add_bias = 15;
            1:       add_bias = 45;
            2:       add_bias = 65;
            default: add_bias = 92;
          endcase
        end
        roll = $urandom_range(99);
        if (roll < 3)                         op = OP_CLEAR;
        else if (roll < 3 + add_bias * 97 / 100) op = OP_ADD;
        else if ($urandom_range(1) == 0)      op = OP_REMOVE;
        else                                  op = OP_QUERY;

        case ($urandom_range(9))
          0: value = $urandom();
          1: begin
            case ($urandom_range(3))
              0:       value = 32'h8000_0000;
              1:       value = 32'h7FFF_FFFF;
              2:       value = 32'h0000_0000;
              default: value = 32'hFFFF_FFFF;
            endcase
          end
          default: value = value_pool[$urandom_range(5)];
        endcase
        send_command(op, value, Predicted, FromPredictor);
      end
    end

    // Drain: wait for every owed result, then give the block time to show
    // anything it should not.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS fixed_capacity_multiset_bag");
    end else begin
      $display("FAIL fixed_capacity_multiset_bag");
    end
    $finish;
  end

endmodule
